@@ rtl/sbr_pkg.sv @@
package sbr_pkg;

    // Fixed field widths of the request and result items.
    localparam int unsigned INDEX_W = 64;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned FREE_W  = 7;
    localparam int unsigned COUNT_W = 7;

    typedef struct packed {
        logic [INDEX_W-1:0] byte_index;
        logic [BYTE_W-1:0]  byte_value;
        logic               has_byte;
        logic               ends_stream;
        logic [FREE_W-1:0]  downstream_free;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               out_valid;
        logic               last_of_run;
        logic               stream_closed;
        logic [COUNT_W-1:0] pending_count;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCAN,
        ST_CLOSE,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_STATUS
    } state_t;

endpackage

@@ rtl/stream_byte_reassembler.sv @@
// Stream byte reassembler: puts the bytes of a stream back into index order.
// The input channel (s_valid, s_ready, s_data) carries one request per byte,
// tagged with its absolute stream index, or an empty end-of-stream marker.
// The result channel (m_valid, m_ready, m_data) delivers the released bytes
// in index order, or a single status result when a request releases nothing.
// Every result carries the pending byte count and the closed flag as they
// stand once the request has been fully processed; the last result of a
// request has last_of_run set.
// Sequence: each request is first evaluated; one that stores no byte then gives
// its status result. One that stores a byte walks the valid map and checks for
// the close, then gives its status result if it completed no run, or else
// releases each byte of the run through a read state and a load state, set by
// the single read port of the byte store and its registered read data. A new
// request is taken once the last result of the previous one has been loaded
// into the output register.
// Reset (aresetn low, synchronous) clears the valid map, the indices, the
// pending count, the end marking and the closed flag; the byte store itself
// is not cleared, as only slots marked valid are ever read.
// When the receiver stalls, the output register holds its result and the
// release walk waits; s_ready stays low until the last result is loaded.
module stream_byte_reassembler #(
    parameter int unsigned WINDOW = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sbr_pkg::in_item_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sbr_pkg::out_item_t m_data
);

    import sbr_pkg::*;

    // Slot addresses cover the window; counts must also hold the window itself.
    localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
    localparam logic [FREE_W-1:0] WIN_FREE = FREE_W'(WINDOW);
    localparam logic [SLOT_W:0]   WIN_SUM  = (SLOT_W + 1)'(WINDOW);
    localparam logic [CNT_W-1:0]  WIN_CNT  = CNT_W'(WINDOW);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

    state_t state_reg, state_next;

    // Architectural state of the reassembler.
    in_item_t            item_reg,       item_next;
    logic [INDEX_W-1:0]  next_index_reg, next_index_next;
    logic [INDEX_W-1:0]  end_index_reg,  end_index_next;
    logic                end_known_reg,  end_known_next;
    logic                closed_reg,     closed_next;
    logic [CNT_W-1:0]    count_reg,      count_next;
    logic [SLOT_W-1:0]   next_slot_reg,  next_slot_next;
    logic [WINDOW-1:0]   valid_reg,      valid_next;

    // Release walk.
    logic [CNT_W-1:0]    run_len_reg,    run_len_next;
    logic [SLOT_W-1:0]   emit_ptr_reg,   emit_ptr_next;
    logic [CNT_W-1:0]    emit_left_reg,  emit_left_next;

    // Output register.
    out_item_t           out_reg,        out_next;
    logic                m_valid_reg,    m_valid_next;

    // Byte store: one write port, one registered read port.
    logic [BYTE_W-1:0]   byte_store [WINDOW];
    logic [BYTE_W-1:0]   rd_data_reg;
    logic                mem_we;
    logic                mem_re;

    // Evaluation of the held request.
    logic [FREE_W-1:0]   free_sat;
    logic [INDEX_W-1:0]  end_new;
    logic [INDEX_W-1:0]  end_eff;
    logic                end_known_eff;
    logic [INDEX_W:0]    diff;
    logic                in_window;
    logic [SLOT_W:0]     slot_sum;
    logic [SLOT_W-1:0]   slot;
    logic                take_byte;
    logic                marker_close;
    logic                scan_hit;
    logic                out_free;
    logic [SLOT_W-1:0]   next_slot_inc;
    logic [SLOT_W-1:0]   emit_ptr_inc;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        free_sat = (item_reg.downstream_free > WIN_FREE) ? WIN_FREE : item_reg.downstream_free;
        end_new  = item_reg.byte_index + {{(INDEX_W-1){1'b0}}, item_reg.has_byte};
        end_eff       = item_reg.ends_stream ? end_new : end_index_reg;
        end_known_eff = item_reg.ends_stream || end_known_reg;

        // The byte lies in the window when it is not below the next index and
        // its offset stays below the free space.
        diff = {1'b0, item_reg.byte_index} - {1'b0, next_index_reg};
        in_window = !diff[INDEX_W] && (diff[INDEX_W-1:FREE_W] == '0)
                    && (diff[FREE_W-1:0] < free_sat);

        // The offset is below the window here, so one subtraction wraps it.
        slot_sum = {1'b0, next_slot_reg} + {1'b0, diff[SLOT_W-1:0]};
        slot     = (slot_sum >= WIN_SUM) ? SLOT_W'(slot_sum - WIN_SUM) : slot_sum[SLOT_W-1:0];

        take_byte    = (free_sat != '0) && item_reg.has_byte && !closed_reg && in_window
                       && !valid_reg[slot];
        marker_close = (free_sat != '0) && !item_reg.has_byte && end_known_eff
                       && (next_index_reg == end_eff);

        scan_hit = valid_reg[next_slot_reg] && (run_len_reg != WIN_CNT);

        next_slot_inc = (next_slot_reg == LAST_SLOT) ? '0 : next_slot_reg + 1'b1;
        emit_ptr_inc  = (emit_ptr_reg == LAST_SLOT) ? '0 : emit_ptr_reg + 1'b1;
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = take_byte ? ST_SCAN : ST_STATUS;
            end
            ST_SCAN: begin
                if (!scan_hit) begin
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                state_next = (run_len_reg == '0) ? ST_STATUS : ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (out_free) begin
                    state_next = (emit_left_reg == CNT_W'(1)) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output logic.
    always_comb begin
        item_next       = item_reg;
        next_index_next = next_index_reg;
        end_index_next  = end_index_reg;
        end_known_next  = end_known_reg;
        closed_next     = closed_reg;
        count_next      = count_reg;
        next_slot_next  = next_slot_reg;
        valid_next      = valid_reg;
        run_len_next    = run_len_reg;
        emit_ptr_next   = emit_ptr_reg;
        emit_left_next  = emit_left_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        s_ready         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next = s_data;
                end
            end
            ST_EVAL: begin
                // The end marking is taken before any other check.
                if (item_reg.ends_stream) begin
                    end_known_next = 1'b1;
                    end_index_next = end_new;
                end
                if (marker_close) begin
                    closed_next = 1'b1;
                end
                if (take_byte) begin
                    mem_we           = 1'b1;
                    valid_next[slot] = 1'b1;
                    count_next       = count_reg + 1'b1;
                end
                run_len_next  = '0;
                emit_ptr_next = next_slot_reg;
            end
            ST_SCAN: begin
                // Walk the contiguous run, retiring one slot per cycle.
                if (scan_hit) begin
                    valid_next[next_slot_reg] = 1'b0;
                    count_next      = count_reg - 1'b1;
                    next_index_next = next_index_reg + 1'b1;
                    next_slot_next  = next_slot_inc;
                    run_len_next    = run_len_reg + 1'b1;
                end
            end
            ST_CLOSE: begin
                if (end_known_reg && (end_index_reg <= next_index_reg)) begin
                    closed_next = 1'b1;
                end
                emit_left_next = run_len_reg;
            end
            ST_EMIT_RD: begin
                mem_re = 1'b1;
            end
            ST_EMIT_LD: begin
                if (out_free) begin
                    out_next.out_byte      = rd_data_reg;
                    out_next.out_valid     = 1'b1;
                    out_next.last_of_run   = (emit_left_reg == CNT_W'(1));
                    out_next.stream_closed = closed_reg;
                    out_next.pending_count = COUNT_W'(count_reg);
                    m_valid_next   = 1'b1;
                    emit_ptr_next  = emit_ptr_inc;
                    emit_left_next = emit_left_reg - 1'b1;
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    out_next.out_byte      = '0;
                    out_next.out_valid     = 1'b0;
                    out_next.last_of_run   = 1'b1;
                    out_next.stream_closed = closed_reg;
                    out_next.pending_count = COUNT_W'(count_reg);
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                m_valid_next = m_valid_reg && !m_ready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            next_index_reg <= '0;
            end_index_reg  <= '0;
            end_known_reg  <= 1'b0;
            closed_reg     <= 1'b0;
            count_reg      <= '0;
            next_slot_reg  <= '0;
            valid_reg      <= '0;
            run_len_reg    <= '0;
            emit_left_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            next_index_reg <= next_index_next;
            end_index_reg  <= end_index_next;
            end_known_reg  <= end_known_next;
            closed_reg     <= closed_next;
            count_reg      <= count_next;
            next_slot_reg  <= next_slot_next;
            valid_reg      <= valid_next;
            run_len_reg    <= run_len_next;
            emit_left_reg  <= emit_left_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        emit_ptr_reg <= emit_ptr_next;
        out_reg      <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            byte_store[slot] <= item_reg.byte_value;
        end
        if (mem_re) begin
            rd_data_reg <= byte_store[emit_ptr_reg];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
